// ----- design/bqwm_pkg.sv -----
// shared types, control codes and the sequencer microprogram for the biquad wet-mix block
`default_nettype none
package bqwm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 24;
    localparam int WET_W      = 16;
    localparam int Q16_W      = 17;
    localparam int Y_W        = 20;
    localparam int STATE_W    = 40;
    localparam int MULB_W     = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 4;

    localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WET    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIX    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd7;

    // multiplier operand selection
    typedef logic [3:0] mul_sel_t;
    localparam mul_sel_t MUL_NONE     = 4'd0;
    localparam mul_sel_t MUL_MIXRAMP  = 4'd1;
    localparam mul_sel_t MUL_B0X      = 4'd2;
    localparam mul_sel_t MUL_B0X_NXT  = 4'd3;
    localparam mul_sel_t MUL_B1X      = 4'd4;
    localparam mul_sel_t MUL_B2X      = 4'd5;
    localparam mul_sel_t MUL_A1Y      = 4'd6;
    localparam mul_sel_t MUL_A2Y      = 4'd7;
    localparam mul_sel_t MUL_YWET     = 4'd8;
    localparam mul_sel_t MUL_WDX      = 4'd9;

    // operation on the registered product
    typedef logic [3:0] alu_op_t;
    localparam alu_op_t OP_NONE = 4'd0;
    localparam alu_op_t OP_RAMP = 4'd1;
    localparam alu_op_t OP_M    = 4'd2;
    localparam alu_op_t OP_Y    = 4'd3;
    localparam alu_op_t OP_LOAD = 4'd4;
    localparam alu_op_t OP_Z1   = 4'd5;
    localparam alu_op_t OP_Z2   = 4'd6;
    localparam alu_op_t OP_W    = 4'd7;
    localparam alu_op_t OP_OUT  = 4'd8;

    // sequencing
    typedef logic [1:0] jmp_t;
    localparam jmp_t JMP_NEXT = 2'd0;
    localparam jmp_t JMP_CHAN = 2'd1;
    localparam jmp_t JMP_DONE = 2'd2;

    localparam logic [STEP_W-1:0] LOOP_STEP = 4'd3;

    typedef struct packed {
        mul_sel_t            mul_sel;
        alu_op_t             alu_op;
        jmp_t                jmp;
        logic [STEP_W-1:0]   jmp_addr;
    } ucode_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        alu_op_t  alu_op;
        logic     ch;
        logic     finish;
    } seq_ctrl_t;

    // microprogram: the multiply issued in a step is consumed by the next step's op
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            4'd0:  w = '{MUL_NONE,    OP_RAMP, JMP_NEXT, 4'd0};
            4'd1:  w = '{MUL_MIXRAMP, OP_NONE, JMP_NEXT, 4'd0};
            4'd2:  w = '{MUL_B0X,     OP_M,    JMP_NEXT, 4'd0};
            4'd3:  w = '{MUL_B1X,     OP_Y,    JMP_NEXT, 4'd0};
            4'd4:  w = '{MUL_A1Y,     OP_LOAD, JMP_NEXT, 4'd0};
            4'd5:  w = '{MUL_B2X,     OP_Z1,   JMP_NEXT, 4'd0};
            4'd6:  w = '{MUL_A2Y,     OP_LOAD, JMP_NEXT, 4'd0};
            4'd7:  w = '{MUL_YWET,    OP_Z2,   JMP_NEXT, 4'd0};
            4'd8:  w = '{MUL_NONE,    OP_W,    JMP_NEXT, 4'd0};
            4'd9:  w = '{MUL_WDX,     OP_NONE, JMP_NEXT, 4'd0};
            4'd10: w = '{MUL_B0X_NXT, OP_OUT,  JMP_CHAN, LOOP_STEP};
            4'd11: w = '{MUL_NONE,    OP_NONE, JMP_DONE, 4'd0};
            default: w = '{MUL_NONE,  OP_NONE, JMP_DONE, 4'd0};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ----- design/biquad_filter_with_wet_mix_ramp.sv -----
// top level: stereo transposed direct form II biquad with wet gain, dry/wet mix and weight ramp
// Stereo biquad effect. Each accepted word is one frame (left and right Q1.15 samples).
// Per frame the effect weight first steps toward the target weight by at most RAMP_STEP,
// the mix factor m = mix_level * weight is formed, and then each channel runs through a
// transposed direct form II biquad (Q4.20 coefficients, 40 bit Q5.35 delay words), the
// filter output is scaled by wet_gain (Q4.12) and blended with the dry sample by m; the
// result saturates to 16 bits. All products go through one shared 21 x 24 bit multiplier,
// stepped by a 12-step microprogram that runs its per-channel steps once for each channel.
// A frame occupies the block until its result has been handed to the output register, and
// a new frame is taken in the cycle after that, never while one is being computed. The
// output register holds a finished frame while the next one is being computed; if it is
// still occupied when the next frame is done, the sequencer waits on its last step.
// Configuration writes are taken at any time (cfg_ready is always high) but must only
// be issued while the block is idle; an index beyond the register list is ignored.
// With CHANNELS = 1 only the left sample is filtered and m_right_out stays zero.
`default_nettype none
module biquad_filter_with_wet_mix_ramp #(
    parameter int RAMP_STEP      = 27,
    parameter int CHANNELS       = 2,
    parameter int COEF_FRAC_BITS = 20
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // frame input
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic signed [bqwm_pkg::SAMPLE_W-1:0]    s_left_in,
    input  wire logic signed [bqwm_pkg::SAMPLE_W-1:0]    s_right_in,
    // frame output
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed [bqwm_pkg::SAMPLE_W-1:0]         m_left_out,
    output logic signed [bqwm_pkg::SAMPLE_W-1:0]         m_right_out,
    // register writes
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [bqwm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [bqwm_pkg::CFG_DATA_W-1:0]         cfg_data
);

    // products carry 15 + COEF_FRAC_BITS fraction bits; the delay words carry 35
    localparam int ALIGN_SH = 35 - 15 - COEF_FRAC_BITS;
    localparam int ALIGN_L  = (ALIGN_SH > 0) ? ALIGN_SH : 0;
    localparam int ALIGN_R  = (ALIGN_SH < 0) ? -ALIGN_SH : 0;
    // b0 must hold its reset value of one, which needs COEF_FRAC_BITS + 2 bits
    localparam int MULA_W   = (COEF_FRAC_BITS + 2 > bqwm_pkg::COEF_W) ?
                              COEF_FRAC_BITS + 2 : bqwm_pkg::COEF_W;
    localparam int MULB_W   = bqwm_pkg::MULB_W;
    localparam int PROD_W   = MULA_W + MULB_W;
    // headroom for the three-term delay update
    localparam int ACC_W    = PROD_W + ALIGN_L + 3;

    localparam int Q16_W    = bqwm_pkg::Q16_W;
    localparam int SAMPLE_W = bqwm_pkg::SAMPLE_W;
    localparam int Y_W      = bqwm_pkg::Y_W;
    localparam int STATE_W  = bqwm_pkg::STATE_W;

    localparam logic signed [18:0] STEP_POS = 19'(RAMP_STEP);
    localparam logic signed [18:0] STEP_NEG = 19'(-RAMP_STEP);

    // saturation helpers on the wide accumulator
    function automatic logic signed [Y_W-1:0] sat_y(input logic signed [ACC_W-1:0] v);
        logic signed [Y_W-1:0] r;
        if (&v[ACC_W-1:Y_W-1] || ~|v[ACC_W-1:Y_W-1]) begin
            r = v[Y_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(Y_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(Y_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_z(input logic signed [ACC_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (&v[ACC_W-1:STATE_W-1] || ~|v[ACC_W-1:STATE_W-1]) begin
            r = v[STATE_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(STATE_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_o(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (&v[ACC_W-1:SAMPLE_W-1] || ~|v[ACC_W-1:SAMPLE_W-1]) begin
            r = v[SAMPLE_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return r;
    endfunction

    // configuration registers
    logic signed [MULA_W-1:0]               coef_b0_reg;
    logic signed [bqwm_pkg::COEF_W-1:0]     coef_b1_reg, coef_b2_reg, coef_a1_reg, coef_a2_reg;
    logic [bqwm_pkg::WET_W-1:0]             wet_gain_reg;
    logic [Q16_W-1:0]                       mix_level_reg, target_weight_reg;

    // frame state and datapath registers
    logic [Q16_W-1:0]                       ramp_reg, ramp_next;
    logic [Q16_W-1:0]                       m_reg, m_next;
    logic signed [Y_W-1:0]                  y_reg, y_next;
    logic signed [MULB_W-1:0]               dw_reg, dw_next;
    logic signed [ACC_W-1:0]                acc_reg, acc_next;
    logic signed [PROD_W-1:0]               prod_reg;
    logic signed [STATE_W-1:0]              z1_reg [2];
    logic signed [STATE_W-1:0]              z1_next [2];
    logic signed [STATE_W-1:0]              z2_reg [2];
    logic signed [STATE_W-1:0]              z2_next [2];
    logic signed [SAMPLE_W-1:0]             x_reg [2];
    logic signed [SAMPLE_W-1:0]             res_reg [2];
    logic signed [SAMPLE_W-1:0]             res_next [2];
    logic signed [SAMPLE_W-1:0]             out_reg [2];
    logic                                   m_valid_reg, m_valid_next;

    // sequencer
    logic                                   busy;
    logic                                   in_accept;
    logic                                   out_free;
    bqwm_pkg::seq_ctrl_t                    ctrl;

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = !busy;
    assign cfg_ready = 1'b1;

    bqwm_seq #(
        .CHANNELS (CHANNELS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_accept),
        .out_free (out_free),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    // sample of the channel being worked on, and of the next one for the early b0 multiply
    logic signed [SAMPLE_W-1:0] x_cur, x_nxt;
    assign x_cur = x_reg[ctrl.ch];
    assign x_nxt = x_reg[~ctrl.ch];

    // mix and target above one count as one
    logic [Q16_W-1:0] mix_clamp, tgt_clamp;
    assign mix_clamp = (mix_level_reg > bqwm_pkg::ONE_Q16) ? bqwm_pkg::ONE_Q16 : mix_level_reg;
    assign tgt_clamp = (target_weight_reg > bqwm_pkg::ONE_Q16) ?
                       bqwm_pkg::ONE_Q16 : target_weight_reg;

    // shared multiplier operand select
    logic signed [MULA_W-1:0] mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.mul_sel)
            bqwm_pkg::MUL_MIXRAMP: begin
                mul_a = MULA_W'(mix_clamp);
                mul_b = MULB_W'(ramp_reg);
            end
            bqwm_pkg::MUL_B0X: begin
                mul_a = coef_b0_reg;
                mul_b = MULB_W'(x_cur);
            end
            bqwm_pkg::MUL_B0X_NXT: begin
                mul_a = coef_b0_reg;
                mul_b = MULB_W'(x_nxt);
            end
            bqwm_pkg::MUL_B1X: begin
                mul_a = MULA_W'(coef_b1_reg);
                mul_b = MULB_W'(x_cur);
            end
            bqwm_pkg::MUL_B2X: begin
                mul_a = MULA_W'(coef_b2_reg);
                mul_b = MULB_W'(x_cur);
            end
            bqwm_pkg::MUL_A1Y: begin
                mul_a = MULA_W'(coef_a1_reg);
                mul_b = MULB_W'(y_reg);
            end
            bqwm_pkg::MUL_A2Y: begin
                mul_a = MULA_W'(coef_a2_reg);
                mul_b = MULB_W'(y_reg);
            end
            bqwm_pkg::MUL_YWET: begin
                mul_a = MULA_W'(wet_gain_reg);
                mul_b = MULB_W'(y_reg);
            end
            bqwm_pkg::MUL_WDX: begin
                mul_a = MULA_W'(m_reg);
                mul_b = dw_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // product aligned to the 35 fraction bits of the delay words
    logic signed [ACC_W-1:0] prod_ext, aligned;
    assign prod_ext = ACC_W'(prod_reg);

    generate
        if (ALIGN_SH >= 0) begin : g_align_left
            assign aligned = prod_ext <<< ALIGN_SH;
        end else begin : g_align_right
            // round half up on the dropped bits
            assign aligned = (prod_ext + (ACC_W'(1) <<< (ALIGN_R - 1))) >>> ALIGN_R;
        end
    endgenerate

    // candidate results of each op
    logic signed [ACC_W-1:0]  sum_y, y_raw, sum_z1, sum_z2, w_raw, m_raw, o_raw;
    logic signed [Y_W-1:0]    w_sat;
    logic [Q16_W-1:0]         m_val, ramp_step;
    logic signed [18:0]       ramp_diff;

    // y = round(b0*x + z1) to 15 fraction bits
    assign sum_y  = aligned + ACC_W'(z1_reg[ctrl.ch]);
    assign y_raw  = (sum_y + (ACC_W'(1) <<< 19)) >>> 20;
    // new delay words
    assign sum_z1 = acc_reg - aligned + ACC_W'(z2_reg[ctrl.ch]);
    assign sum_z2 = acc_reg - aligned;
    // wet path: y * wet_gain back to 15 fraction bits
    assign w_raw  = (prod_ext + (ACC_W'(1) <<< 11)) >>> 12;
    assign w_sat  = sat_y(w_raw);
    // blend: x + (w - x) * m
    assign o_raw  = ACC_W'(x_cur) + ((prod_ext + (ACC_W'(1) <<< 15)) >>> 16);
    // mix factor, product is never negative
    assign m_raw  = (prod_ext + (ACC_W'(1) <<< 15)) >>> 16;
    assign m_val  = (m_raw > $signed(ACC_W'(bqwm_pkg::ONE_Q16))) ?
                    bqwm_pkg::ONE_Q16 : m_raw[Q16_W-1:0];

    // weight ramp, at most RAMP_STEP per frame
    assign ramp_diff = $signed({2'b00, tgt_clamp}) - $signed({2'b00, ramp_reg});
    assign ramp_step = (ramp_diff > STEP_POS) ? ramp_reg + Q16_W'(RAMP_STEP) :
                       (ramp_diff < STEP_NEG) ? ramp_reg - Q16_W'(RAMP_STEP) : tgt_clamp;

    always_comb begin
        ramp_next = ramp_reg;
        m_next    = m_reg;
        y_next    = y_reg;
        dw_next   = dw_reg;
        acc_next  = acc_reg;
        z1_next   = z1_reg;
        z2_next   = z2_reg;
        res_next  = res_reg;
        unique case (ctrl.alu_op)
            bqwm_pkg::OP_RAMP: ramp_next = ramp_step;
            bqwm_pkg::OP_M:    m_next    = m_val;
            bqwm_pkg::OP_Y:    y_next    = sat_y(y_raw);
            bqwm_pkg::OP_LOAD: acc_next  = aligned;
            bqwm_pkg::OP_Z1:   z1_next[ctrl.ch] = sat_z(sum_z1);
            bqwm_pkg::OP_Z2:   z2_next[ctrl.ch] = sat_z(sum_z2);
            bqwm_pkg::OP_W:    dw_next   = MULB_W'(w_sat) - MULB_W'(x_cur);
            bqwm_pkg::OP_OUT:  res_next[ctrl.ch] = sat_o(o_raw);
            default: ;
        endcase
    end

    // output word register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control, configuration and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_b0_reg       <= MULA_W'(1) <<< COEF_FRAC_BITS;
            coef_b1_reg       <= '0;
            coef_b2_reg       <= '0;
            coef_a1_reg       <= '0;
            coef_a2_reg       <= '0;
            wet_gain_reg      <= 16'd4096;
            mix_level_reg     <= bqwm_pkg::ONE_Q16;
            target_weight_reg <= '0;
            ramp_reg          <= '0;
            for (int i = 0; i < 2; i++) begin
                z1_reg[i] <= '0;
                z2_reg[i] <= '0;
            end
            m_valid_reg       <= 1'b0;
        end else begin
            ramp_reg    <= ramp_next;
            z1_reg      <= z1_next;
            z2_reg      <= z2_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    bqwm_pkg::REG_B0:     coef_b0_reg <= MULA_W'($signed(cfg_data));
                    bqwm_pkg::REG_B1:     coef_b1_reg <= $signed(cfg_data);
                    bqwm_pkg::REG_B2:     coef_b2_reg <= $signed(cfg_data);
                    bqwm_pkg::REG_A1:     coef_a1_reg <= $signed(cfg_data);
                    bqwm_pkg::REG_A2:     coef_a2_reg <= $signed(cfg_data);
                    bqwm_pkg::REG_WET:    wet_gain_reg <= cfg_data[bqwm_pkg::WET_W-1:0];
                    bqwm_pkg::REG_MIX:    mix_level_reg <= cfg_data[Q16_W-1:0];
                    bqwm_pkg::REG_TARGET: target_weight_reg <= cfg_data[Q16_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath payload, no reset needed
    always_ff @(posedge aclk) begin
        m_reg   <= m_next;
        y_reg   <= y_next;
        dw_reg  <= dw_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
        if (ctrl.mul_sel != bqwm_pkg::MUL_NONE) begin
            prod_reg <= mul_p;
        end
        if (in_accept) begin
            x_reg[0] <= s_left_in;
            x_reg[1] <= s_right_in;
        end
        if (ctrl.finish) begin
            out_reg <= res_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = out_reg[0];
    // mono build leaves the right output at zero
    assign m_right_out = (CHANNELS > 1) ? out_reg[1] : '0;

endmodule
`default_nettype wire

// ----- design/bqwm_seq.sv -----
// microcode sequencer: step counter, channel counter and conditional jumps
`default_nettype none
module bqwm_seq #(
    parameter int CHANNELS = 2
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic                 out_free,
    output logic                      busy,
    output bqwm_pkg::seq_ctrl_t       ctrl
);

    localparam logic LAST_CH = 1'(CHANNELS - 1);

    logic [bqwm_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        ch_reg, ch_next;
    logic                        busy_reg, busy_next;
    logic                        finish;
    bqwm_pkg::ucode_t            uw;

    assign uw = bqwm_pkg::ucode_rom(step_reg);

    always_comb begin
        step_next = step_reg;
        ch_next   = ch_reg;
        busy_next = busy_reg;
        finish    = 1'b0;
        if (!busy_reg) begin
            if (start) begin
                busy_next = 1'b1;
                step_next = '0;
                ch_next   = 1'b0;
            end
        end else begin
            unique case (uw.jmp)
                bqwm_pkg::JMP_NEXT: begin
                    step_next = step_reg + 1'b1;
                end
                bqwm_pkg::JMP_CHAN: begin
                    if (ch_reg != LAST_CH) begin
                        ch_next   = ch_reg + 1'b1;
                        step_next = uw.jmp_addr;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
                bqwm_pkg::JMP_DONE: begin
                    // hold here until the result register can take the word
                    if (out_free) begin
                        finish    = 1'b1;
                        busy_next = 1'b0;
                        step_next = '0;
                    end
                end
                default: begin
                    busy_next = 1'b0;
                    step_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            ch_reg   <= 1'b0;
            busy_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            ch_reg   <= ch_next;
            busy_reg <= busy_next;
        end
    end

    assign busy         = busy_reg;
    assign ctrl.mul_sel = busy_reg ? uw.mul_sel : bqwm_pkg::MUL_NONE;
    assign ctrl.alu_op  = busy_reg ? uw.alu_op : bqwm_pkg::OP_NONE;
    assign ctrl.ch      = ch_reg;
    assign ctrl.finish  = finish;

endmodule
`default_nettype wire
